FILE: hw/rtl/sbm_pkg.sv
// Shared constants and types for the stereo block-matching depth block.
// Used by sbm_sqrt, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package sbm_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_BOX_HALF_DEF = 8;
    localparam int MAX_SEARCH_DEF   = 8;

    // Field widths of the stream and configuration ports
    localparam int PIX_W      = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int ROW_W      = 12;
    localparam int IMG_W_W    = 11;
    localparam int BOX_CFG_W  = 4;
    localparam int SR_CFG_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DEPTH_W    = 12;
    localparam int OFS_W      = 5;

    // Depth is a 4.8 fixed-point length, so the square is scaled by two fraction widths
    localparam int FRAC_BITS = 8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 12'd4095;

    // Command carried in tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Register reset values
    localparam logic [IMG_W_W-1:0]   IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0]     IMAGE_HEIGHT_RST = 12'd480;
    localparam logic [BOX_CFG_W-1:0] BOX_HALF_RST     = 4'd2;
    localparam logic [SR_CFG_W-1:0]  SEARCH_RST       = 4'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_BOX_HALF_WIDTH  = 3'd2,
        REG_BOX_HALF_HEIGHT = 3'd3,
        REG_SEARCH_RANGE    = 3'd4
    } cfg_reg_t;

    // Handshake between the controller and the square-root unit
    typedef struct packed {
        logic start;
        logic done;
    } sqrt_ctl_t;

endpackage

FILE: hw/rtl/sbm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/sbm_sqrt.sv
// Digit-serial square root giving the rounded 4.8 fixed-point length of a squared offset.
// Depends on sbm_pkg.
`timescale 1ns / 1ps

module sbm_sqrt #(
    parameter int D2_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [D2_W-1:0]             d2,
    output logic                        done,
    output logic [sbm_pkg::DEPTH_W-1:0] depth
);

    localparam int STEPS = (D2_W + 2 * sbm_pkg::FRAC_BITS + 1) / 2;
    localparam int N_W   = 2 * STEPS;
    localparam int R_W   = STEPS;
    localparam int REM_W = STEPS + 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [N_W-1:0]   n_reg;
    logic [R_W-1:0]   root_reg;
    logic [REM_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [sbm_pkg::DEPTH_W-1:0] depth_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [R_W:0]     rounded;

    // One result bit per step: bring down two bits and try to subtract
    assign rem_sh  = {rem_reg[REM_W-3:0], n_reg[N_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign rounded = {1'b0, root_reg} + (((R_W + 1)'(rem_reg) > (R_W + 1)'(root_reg)) ? 1'b1 : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Datapath of the root, the remainder and the rounding
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= N_W'(d2) << (2 * sbm_pkg::FRAC_BITS);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == CNT_W'(STEPS))
            begin
                if (rounded > (R_W + 1)'(sbm_pkg::DEPTH_MAX))
                begin
                    depth_reg <= sbm_pkg::DEPTH_MAX;
                end
                else
                begin
                    depth_reg <= sbm_pkg::DEPTH_W'(rounded);
                end
            end
            else
            begin
                n_reg <= n_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[R_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[R_W-2:0], 1'b0};
                end
            end
        end
    end

    assign done  = done_reg;
    assign depth = depth_reg;

endmodule

FILE: hw/rtl/stereo_block_match_depth.sv
// Stereo block-matching depth block: pixel pairs in raster order go into two line-store
// RAMs, each request is followed by at most one depth result, once one has become computable.
// Depends on sbm_pkg, sbm_ram and sbm_sqrt.
`timescale 1ns / 1ps

// The block takes one request at a time. A pixel or drain request that makes no result
// ready goes from S_CHECK back to S_IDLE. One that yields a result visits each of the
// C = (2sr+1)^2 candidate offsets once; for the V of them that fit in the image it reads
// the (2bw+1)*(2bh+1) box pixels one at a time, because each line store has a single read
// port. The square root of the best offset length is taken once the cost pipeline drains.
// Border pixels and a zero search range skip the scan and give a zero result. The line
// stores need no clearing after reset. A finished result waits in an output register, and
// the next request is taken while it waits.
module stereo_block_match_depth #(
    parameter int MAX_WIDTH    = sbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_BOX_HALF = sbm_pkg::MAX_BOX_HALF_DEF,
    parameter int MAX_SEARCH   = sbm_pkg::MAX_SEARCH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: left_pixel [7:0], right_pixel [15:8]
    input  logic [sbm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd (0 pixel pair, 1 drain)
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: depth_value [11:0], best_dx [16:12], best_dy [21:17], zero fill [23:22]
    output logic [sbm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_write,
    input  logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int RING   = 2 * (MAX_BOX_HALF + MAX_SEARCH) + 2;
    localparam int RING_W = $clog2(RING);
    localparam int RS_W   = RING_W + 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = sbm_pkg::ROW_W;
    localparam int XP_W   = COL_W + 8;
    localparam int YP_W   = ROW_W + 8;
    localparam int HB_W   = $clog2(MAX_BOX_HALF + 1);
    localparam int SR_W   = $clog2(MAX_SEARCH + 1);
    localparam int BO_W   = HB_W + 1;
    localparam int SO_W   = SR_W + 1;
    localparam int D2_W   = $clog2(2 * MAX_SEARCH * MAX_SEARCH + 1);
    localparam int PIX_W  = sbm_pkg::PIX_W;
    localparam int SQ_W   = 2 * PIX_W;
    localparam int COST_W = SQ_W + $clog2((2 * MAX_BOX_HALF + 1) * (2 * MAX_BOX_HALF + 1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CAND,
        S_BOX,
        S_DRAIN,
        S_SQRT,
        S_EMIT
    } state_t;

    // Configuration registers
    logic [sbm_pkg::IMG_W_W-1:0]   img_w_reg;
    logic [ROW_W-1:0]              img_h_reg;
    logic [sbm_pkg::BOX_CFG_W-1:0] box_w_reg;
    logic [sbm_pkg::BOX_CFG_W-1:0] box_h_reg;
    logic [sbm_pkg::SR_CFG_W-1:0]  search_reg;

    // Effective sizes after clamping
    logic [COL_W:0]  w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [HB_W-1:0] bw_eff;
    logic [HB_W-1:0] bh_eff;
    logic [SR_W-1:0] sr_eff;

    // Controller state
    state_t state_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [RING_W-1:0] in_ring_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [RING_W-1:0] out_ring_reg;
    logic              frame_in_reg;
    logic              zero_res_reg;
    logic signed [SO_W-1:0] dx_reg;
    logic signed [SO_W-1:0] dy_reg;
    logic signed [BO_W-1:0] bx_reg;
    logic signed [BO_W-1:0] by_reg;

    // Best match so far
    logic              have_reg;
    logic [COST_W-1:0] best_cost_reg;
    logic [D2_W-1:0]   best_d2_reg;
    logic signed [SO_W-1:0] bdx_reg;
    logic signed [SO_W-1:0] bdy_reg;
    logic [sbm_pkg::DEPTH_W-1:0] depth_res_reg;

    // Output register
    logic                         out_valid_reg;
    logic [sbm_pkg::DEPTH_W-1:0]  out_depth_reg;
    logic [sbm_pkg::OFS_W-1:0]    out_dx_reg;
    logic [sbm_pkg::OFS_W-1:0]    out_dy_reg;
    logic                         out_last_reg;

    // Cost pipeline: read data, then square, then accumulate and compare
    logic p1_valid_reg, p1_first_reg, p1_last_reg;
    logic signed [SO_W-1:0] p1_dx_reg, p1_dy_reg;
    logic p2_valid_reg, p2_first_reg, p2_last_reg;
    logic signed [SO_W-1:0] p2_dx_reg, p2_dy_reg;
    logic [D2_W-1:0]   p2_d2_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [COST_W-1:0] acc_reg;

    logic [PIX_W-1:0] l_rd;
    logic [PIX_W-1:0] r_rd;

    // Handshakes and decoded conditions
    logic in_fire;
    logic wr_pix;
    logic out_free;
    logic ready;
    logic border;
    logic cand_ok;
    logic cand_last;
    logic box_last;
    logic pipe_empty;
    logic better;
    logic [COST_W-1:0] acc_sum;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    ocol_inc;
    logic [ROW_W:0]    orow_inc;

    logic signed [XP_W-1:0] x_s, bw_x, w_x, x_dx, in_col_s, need_col, need_col_raw;
    logic signed [YP_W-1:0] y_s, bh_y, h_y, sr_y, y_dy, in_row_s, need_row, need_row_raw;
    logic signed [SO_W-1:0] sr_s;
    logic signed [BO_W-1:0] bw_b, bh_b;

    logic [RING_W-1:0] l_ring, r_ring;
    logic [COL_W-1:0]  l_col, r_col;
    logic [ADDR_W-1:0] wr_addr, rd_addr_l, rd_addr_r;

    logic signed [PIX_W:0]       diff;
    logic signed [2*PIX_W+1:0]   sq_full;
    logic signed [2*SO_W-1:0]    dxx, dyy;

    sbm_pkg::sqrt_ctl_t sq_ctl;
    logic [sbm_pkg::DEPTH_W-1:0] sq_depth;

    // Wrap a ring row index that has been moved by a small signed offset
    function automatic logic [RING_W-1:0] ring_wrap(input logic signed [RS_W-1:0] v);
        logic signed [RS_W-1:0] t;
        t = v;
        if (t < 0)
        begin
            t = t + RS_W'(RING);
        end
        else if (t >= RS_W'(RING))
        begin
            t = t - RS_W'(RING);
        end
        return RING_W'(t);
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg  <= sbm_pkg::IMAGE_WIDTH_RST;
            img_h_reg  <= sbm_pkg::IMAGE_HEIGHT_RST;
            box_w_reg  <= sbm_pkg::BOX_HALF_RST;
            box_h_reg  <= sbm_pkg::BOX_HALF_RST;
            search_reg <= sbm_pkg::SEARCH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sbm_pkg::REG_IMAGE_WIDTH:     img_w_reg  <= sbm_pkg::IMG_W_W'(cfg_data);
                sbm_pkg::REG_IMAGE_HEIGHT:    img_h_reg  <= ROW_W'(cfg_data);
                sbm_pkg::REG_BOX_HALF_WIDTH:  box_w_reg  <= sbm_pkg::BOX_CFG_W'(cfg_data);
                sbm_pkg::REG_BOX_HALF_HEIGHT: box_h_reg  <= sbm_pkg::BOX_CFG_W'(cfg_data);
                sbm_pkg::REG_SEARCH_RANGE:    search_reg <= sbm_pkg::SR_CFG_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // Clamp the registers to the sizes the hardware supports
    always_comb
    begin
        if (img_w_reg == '0)
        begin
            w_eff = (COL_W + 1)'(1);
        end
        else if (32'(img_w_reg) > MAX_WIDTH)
        begin
            w_eff = (COL_W + 1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (COL_W + 1)'(img_w_reg);
        end
        h_eff  = (img_h_reg == '0) ? ROW_W'(1) : img_h_reg;
        bw_eff = (32'(box_w_reg) > MAX_BOX_HALF) ? HB_W'(MAX_BOX_HALF) : HB_W'(box_w_reg);
        bh_eff = (32'(box_h_reg) > MAX_BOX_HALF) ? HB_W'(MAX_BOX_HALF) : HB_W'(box_h_reg);
        sr_eff = (32'(search_reg) > MAX_SEARCH) ? SR_W'(MAX_SEARCH) : SR_W'(search_reg);
    end

    // Signed views of positions and sizes
    assign x_s      = XP_W'(out_col_reg);
    assign y_s      = YP_W'(out_row_reg);
    assign bw_x     = XP_W'(bw_eff);
    assign w_x      = XP_W'(w_eff);
    assign bh_y     = YP_W'(bh_eff);
    assign h_y      = YP_W'(h_eff);
    assign sr_y     = YP_W'(sr_eff);
    assign sr_s     = SO_W'(sr_eff);
    assign bw_b     = BO_W'(bw_eff);
    assign bh_b     = BO_W'(bh_eff);
    assign in_col_s = XP_W'(in_col_reg);
    assign in_row_s = YP_W'(in_row_reg);
    assign x_dx     = x_s + XP_W'(dx_reg);
    assign y_dy     = y_s + YP_W'(dy_reg);

    // A result is ready once the last input pixel its window can touch has arrived
    always_comb
    begin
        need_row_raw = y_s + sr_y + bh_y;
        need_row     = (need_row_raw > h_y - 1) ? h_y - 1 : need_row_raw;
        need_col_raw = x_s + XP_W'(sr_eff) + bw_x;
        need_col     = (need_col_raw > w_x - 1) ? w_x - 1 : need_col_raw;
        ready = frame_in_reg || (in_row_s > need_row)
                || ((in_row_s == need_row) && (in_col_s > need_col));
    end

    assign border = (x_s + bw_x >= w_x) || (x_s < bw_x) || (y_s < bh_y) || (y_s + bh_y >= h_y);

    // Candidate offset is kept only where the whole right box lies inside the image
    assign cand_ok = (y_dy - bh_y >= 0) && (y_dy + bh_y < h_y)
                     && (x_dx - bw_x >= 0) && (x_dx + bw_x < w_x);
    assign cand_last = (dx_reg == sr_s) && (dy_reg == sr_s);
    assign box_last  = (bx_reg == bw_b) && (by_reg == bh_b);

    // Handshakes
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign wr_pix   = in_fire && (s_axis_tuser == sbm_pkg::CMD_PIXEL) && !frame_in_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign col_inc  = (COL_W + 1)'(in_col_reg) + 1'b1;
    assign row_inc  = (ROW_W + 1)'(in_row_reg) + 1'b1;
    assign ocol_inc = (COL_W + 1)'(out_col_reg) + 1'b1;
    assign orow_inc = (ROW_W + 1)'(out_row_reg) + 1'b1;
    assign pipe_empty = !p1_valid_reg && !p2_valid_reg;

    // Line-store addresses: ring row times the row pitch plus the column
    assign wr_addr = ADDR_W'(ADDR_W'(in_ring_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg));
    assign l_ring  = ring_wrap(RS_W'(out_ring_reg) + RS_W'(by_reg));
    assign r_ring  = ring_wrap(RS_W'(out_ring_reg) + RS_W'(dy_reg) + RS_W'(by_reg));
    assign l_col   = COL_W'(x_s + XP_W'(bx_reg));
    assign r_col   = COL_W'(x_dx + XP_W'(bx_reg));
    assign rd_addr_l = ADDR_W'(ADDR_W'(l_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(l_col));
    assign rd_addr_r = ADDR_W'(ADDR_W'(r_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_col));

    sbm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_left_rows (
        .clk     (clk),
        .wr_en   (wr_pix),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata[PIX_W-1:0]),
        .rd_addr (rd_addr_l),
        .rd_data (l_rd)
    );

    sbm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_right_rows (
        .clk     (clk),
        .wr_en   (wr_pix),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .rd_addr (rd_addr_r),
        .rd_data (r_rd)
    );

    // Squared difference and offset length of the entries now read
    assign diff    = $signed({1'b0, l_rd}) - $signed({1'b0, r_rd});
    assign sq_full = diff * diff;
    assign dxx     = p1_dx_reg * p1_dx_reg;
    assign dyy     = p1_dy_reg * p1_dy_reg;

    // Accumulated cost and the strict-improvement test
    assign acc_sum = (p2_first_reg ? '0 : acc_reg) + COST_W'(sq_reg);
    assign better  = !have_reg || (acc_sum < best_cost_reg)
                     || ((acc_sum == best_cost_reg) && (p2_d2_reg < best_d2_reg));

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= (state_reg == S_BOX);
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        p1_first_reg <= (bx_reg == -bw_b) && (by_reg == -bh_b);
        p1_last_reg  <= box_last;
        p1_dx_reg    <= dx_reg;
        p1_dy_reg    <= dy_reg;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_dx_reg    <= p1_dx_reg;
        p2_dy_reg    <= p1_dy_reg;
        p2_d2_reg    <= D2_W'(dxx + dyy);
        sq_reg       <= SQ_W'(sq_full);
        if (p2_valid_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    // Square root of the winning offset length
    assign sq_ctl.start = (state_reg == S_DRAIN) && pipe_empty;

    sbm_sqrt #(
        .D2_W (D2_W)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_ctl.start),
        .d2    (best_d2_reg),
        .done  (sq_ctl.done),
        .depth (sq_depth)
    );

    // Controller: input counters, candidate scan, best match and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_ring_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_ring_reg  <= '0;
            frame_in_reg  <= 1'b0;
            zero_res_reg  <= 1'b0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            have_reg      <= 1'b0;
            best_cost_reg <= '0;
            best_d2_reg   <= '0;
            bdx_reg       <= '0;
            bdy_reg       <= '0;
            depth_res_reg <= '0;
            out_valid_reg <= 1'b0;
            out_depth_reg <= '0;
            out_dx_reg    <= '0;
            out_dy_reg    <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Keep the best candidate as each box sum completes
            if (p2_valid_reg && p2_last_reg && better)
            begin
                have_reg      <= 1'b1;
                best_cost_reg <= acc_sum;
                best_d2_reg   <= p2_d2_reg;
                bdx_reg       <= p2_dx_reg;
                bdy_reg       <= p2_dy_reg;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (wr_pix)
                        begin
                            if (col_inc >= w_eff)
                            begin
                                in_col_reg <= '0;
                                if (row_inc >= (ROW_W + 1)'(h_eff))
                                begin
                                    in_row_reg   <= '0;
                                    in_ring_reg  <= '0;
                                    frame_in_reg <= 1'b1;
                                end
                                else
                                begin
                                    in_row_reg  <= ROW_W'(row_inc);
                                    in_ring_reg <= (in_ring_reg == RING_W'(RING - 1)) ? '0
                                                   : in_ring_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                in_col_reg <= COL_W'(col_inc);
                            end
                        end
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    have_reg <= 1'b0;
                    dx_reg   <= -sr_s;
                    dy_reg   <= -sr_s;
                    if (!ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (border || (sr_eff == '0))
                    begin
                        zero_res_reg <= 1'b1;
                        state_reg    <= S_EMIT;
                    end
                    else
                    begin
                        zero_res_reg <= 1'b0;
                        state_reg    <= S_CAND;
                    end
                end

                S_CAND:
                begin
                    bx_reg <= -bw_b;
                    by_reg <= -bh_b;
                    if (cand_ok)
                    begin
                        state_reg <= S_BOX;
                    end
                    else if (cand_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else if (dx_reg == sr_s)
                    begin
                        dx_reg <= -sr_s;
                        dy_reg <= dy_reg + 1'b1;
                    end
                    else
                    begin
                        dx_reg <= dx_reg + 1'b1;
                    end
                end

                S_BOX:
                begin
                    if (box_last)
                    begin
                        if (cand_last)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            state_reg <= S_CAND;
                            if (dx_reg == sr_s)
                            begin
                                dx_reg <= -sr_s;
                                dy_reg <= dy_reg + 1'b1;
                            end
                            else
                            begin
                                dx_reg <= dx_reg + 1'b1;
                            end
                        end
                    end
                    else if (bx_reg == bw_b)
                    begin
                        bx_reg <= -bw_b;
                        by_reg <= by_reg + 1'b1;
                    end
                    else
                    begin
                        bx_reg <= bx_reg + 1'b1;
                    end
                end

                S_DRAIN:
                begin
                    if (pipe_empty)
                    begin
                        state_reg <= S_SQRT;
                    end
                end

                S_SQRT:
                begin
                    if (sq_ctl.done)
                    begin
                        depth_res_reg <= sq_depth;
                        state_reg     <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_depth_reg <= zero_res_reg ? '0 : depth_res_reg;
                        out_dx_reg    <= zero_res_reg ? '0 : sbm_pkg::OFS_W'(bdx_reg);
                        out_dy_reg    <= zero_res_reg ? '0 : sbm_pkg::OFS_W'(bdy_reg);
                        out_last_reg  <= 1'b0;
                        if (ocol_inc >= w_eff)
                        begin
                            out_col_reg <= '0;
                            if (orow_inc >= (ROW_W + 1)'(h_eff))
                            begin
                                out_row_reg  <= '0;
                                out_ring_reg <= '0;
                                out_last_reg <= 1'b1;
                                frame_in_reg <= 1'b0;
                            end
                            else
                            begin
                                out_row_reg  <= ROW_W'(orow_inc);
                                out_ring_reg <= (out_ring_reg == RING_W'(RING - 1)) ? '0
                                                : out_ring_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            out_col_reg <= COL_W'(ocol_inc);
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_dy_reg, out_dx_reg, out_depth_reg};

    // Read data only enters the cost pipeline from a box read
    a_read_from_box: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> $past(state_reg == S_BOX))
        else $error("cost pipeline loaded outside a box scan");

    // The root is taken only after every box sum has been compared
    a_drained_before_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_ctl.start |-> !p1_valid_reg && !p2_valid_reg)
        else $error("square root started with sums still in flight");

    // A complete input frame leaves the input counters at the frame origin
    a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
        frame_in_reg |-> (in_col_reg == '0) && (in_row_reg == '0) && (in_ring_reg == '0))
        else $error("input counters moved while the frame was complete");

    // The line stores are never written while a scan reads them
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BOX) |-> !wr_pix)
        else $error("line store written during a box scan");

endmodule

FILE: bench/stereo_block_match_depth_tb.sv
// Self-checking testbench for stereo_block_match_depth: drives pixel and drain requests,
// predicts each depth result in step with the stimulus and checks what the block returns.
// Depends on sbm_pkg and the block's RTL.
`timescale 1ns / 1ps

module stereo_block_match_depth_tb;

    import sbm_pkg::*;

    localparam int LIM_WIDTH  = 1024;
    localparam int LIM_BOX    = 8;
    localparam int LIM_SEARCH = 8;
    localparam int RING       = 2 * (LIM_BOX + LIM_SEARCH) + 2;
    localparam int MISMATCH_SHOWN = 10;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct {
        logic             cmd;
        logic [PIX_W-1:0] left_pix;
        logic [PIX_W-1:0] right_pix;
    } pixel_req_t;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic [OFS_W-1:0]   dx;
        logic [OFS_W-1:0]   dy;
        logic               last;
    } depth_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pixel_req_t pending_reqs[$];
    depth_res_t expected_depths[$];
    idle_mode_e idle_mode = IDLE_NONE;
    logic       hold_request = 1'b0;
    logic       hold_started = 1'b0;
    int         hold_left = 0;
    int         mismatches = 0;
    int         results_seen = 0;
    int         reqs_sent = 0;
    int         phases_run = 0;

    // Predictor copy of configuration, line stores and raster counters
    logic [IMG_W_W-1:0]   cfg_w;
    logic [ROW_W-1:0]     cfg_h;
    logic [BOX_CFG_W-1:0] cfg_bw;
    logic [BOX_CFG_W-1:0] cfg_bh;
    logic [SR_CFG_W-1:0]  cfg_sr;
    logic [PIX_W-1:0]     left_store[RING * LIM_WIDTH];
    logic [PIX_W-1:0]     right_store[RING * LIM_WIDTH];
    int                   in_col, in_row, out_col, out_row;
    bit                   frame_complete;

    stereo_block_match_depth dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog for a hung run
    initial
    begin
        #40000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int store_slot(int row, int col);
        return (row % RING) * LIM_WIDTH + (col % LIM_WIDTH);
    endfunction

    // Rounded 4.8 fixed-point length from a squared displacement
    function automatic logic [DEPTH_W-1:0] length_fixed(int d2);
        longint unsigned n;
        longint unsigned rem;
        longint unsigned r;
        longint unsigned b;
        n = longint'(d2) << 16;
        rem = n;
        r = 0;
        b = 64'd1 << 30;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (n - r * r > r)
            r = r + 1;
        if (r > 4095)
            r = 4095;
        return r[DEPTH_W-1:0];
    endfunction

    // Best SSD match for one output pixel
    task automatic match_pixel(input int x, input int y, input int w, input int h,
                               input int bw, input int bh, input int sr,
                               output depth_res_t res);
        int         bdx, bdy, bestd2, d2, a, b;
        longint     best, cost;
        bit         have;
        bdx = 0;
        bdy = 0;
        best = 0;
        bestd2 = 0;
        have = 0;
        res.depth = '0;
        res.dx = '0;
        res.dy = '0;
        res.last = 1'b0;
        if (x >= w - bw || x < bw || y < bh || y >= h - bh)
            return;
        for (int dy = -sr; dy <= sr; dy++)
        begin
            if (y + dy - bh < 0 || y + dy + bh >= h)
                continue;
            for (int dx = -sr; dx <= sr; dx++)
            begin
                if (x + dx - bw < 0 || x + dx + bw >= w)
                    continue;
                cost = 0;
                d2 = dx * dx + dy * dy;
                for (int by = -bh; by <= bh; by++)
                    for (int bx = -bw; bx <= bw; bx++)
                    begin
                        a = left_store[store_slot(y + by, x + bx)];
                        b = right_store[store_slot(y + dy + by, x + dx + bx)];
                        cost = cost + (a - b) * (a - b);
                    end
                if (!have || cost < best || (cost == best && d2 < bestd2))
                begin
                    have = 1;
                    best = cost;
                    bestd2 = d2;
                    bdx = dx;
                    bdy = dy;
                end
            end
        end
        if (sr == 0 || !have)
            return;
        res.depth = length_fixed(bestd2);
        res.dx = bdx[OFS_W-1:0];
        res.dy = bdy[OFS_W-1:0];
    endtask

    // Advances the predictor by one request and queues any depth result it makes ready
    task automatic predict_depth(input pixel_req_t req);
        int         w, h, bw, bh, sr, need_row, need_col, s;
        bit         ready;
        depth_res_t res;
        w = clamp_int(cfg_w, 1, LIM_WIDTH);
        h = clamp_int(cfg_h, 1, 4095);
        bw = clamp_int(cfg_bw, 0, LIM_BOX);
        bh = clamp_int(cfg_bh, 0, LIM_BOX);
        sr = clamp_int(cfg_sr, 0, LIM_SEARCH);
        if (req.cmd == CMD_PIXEL && !frame_complete)
        begin
            s = store_slot(in_row, in_col);
            left_store[s] = req.left_pix;
            right_store[s] = req.right_pix;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    frame_complete = 1;
                end
            end
        end
        need_row = out_row + sr + bh;
        if (need_row > h - 1)
            need_row = h - 1;
        need_col = out_col + sr + bw;
        if (need_col > w - 1)
            need_col = w - 1;
        ready = frame_complete || in_row > need_row || (in_row == need_row && in_col > need_col);
        if (!ready)
            return;
        match_pixel(out_col, out_row, w, h, bw, bh, sr, res);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= h)
            begin
                out_row = 0;
                res.last = 1'b1;
                frame_complete = 0;
            end
        end
        expected_depths.push_back(res);
    endtask

    task automatic queue_req(input logic cmd, input logic [PIX_W-1:0] lp,
                             input logic [PIX_W-1:0] rp);
        pixel_req_t req;
        req.cmd = cmd;
        req.left_pix = lp;
        req.right_pix = rp;
        predict_depth(req);
        pending_reqs.push_back(req);
    endtask

    // Random pixel value; a narrow range often, so that equal costs occur
    function automatic logic [PIX_W-1:0] rand_pix(bit narrow);
        if (narrow)
            return PIX_W'($urandom_range(0, 3));
        return PIX_W'($urandom);
    endfunction

    // One frame of pixels with drains scattered in, then a tail of drains and dropped pixels
    task automatic queue_frame(input int drain_pct);
        int  npix;
        bit  narrow;
        npix = clamp_int(cfg_w, 1, LIM_WIDTH) * clamp_int(cfg_h, 1, 4095);
        narrow = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < npix; i++)
        begin
            if ($urandom_range(0, 99) < drain_pct)
                queue_req(CMD_DRAIN, rand_pix(0), rand_pix(0));
            queue_req(CMD_PIXEL, rand_pix(narrow), rand_pix(narrow));
        end
        while (frame_complete)
            queue_req($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_DRAIN,
                      rand_pix(0), rand_pix(0));
    endtask

    // Waits until the block is idle, then writes all five registers
    task automatic set_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] bh,
                              input logic [CFG_DATA_W-1:0] sr);
        logic [CFG_DATA_W-1:0] vals[5];
        cfg_reg_t              regs[5];
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_depths.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        vals = '{w, h, bw, bh, sr};
        regs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BOX_HALF_WIDTH,
                 REG_BOX_HALF_HEIGHT, REG_SEARCH_RANGE};
        for (int i = 0; i < 5; i++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_w = w[IMG_W_W-1:0];
        cfg_h = h[ROW_W-1:0];
        cfg_bw = bw[BOX_CFG_W-1:0];
        cfg_bh = bh[BOX_CFG_W-1:0];
        cfg_sr = sr[SR_CFG_W-1:0];
        phases_run++;
    endtask

    // Request driver: offers the oldest pending request, with random gaps
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            reqs_sent <= reqs_sent + 1;
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_reqs.size() != 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 78) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 23)))
            begin
                s_axis_tdata <= {pending_reqs[0].right_pix, pending_reqs[0].left_pix};
                s_axis_tuser <= pending_reqs[0].cmd;
                s_axis_tvalid <= 1'b1;
                void'(pending_reqs.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted in cycles
    always @(posedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_left <= 3000;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: checks each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        depth_res_t exp_res;
        logic [M_TDATA_W-1:0] exp_data;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_depths.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < MISMATCH_SHOWN)
                    $display("unexpected result: data %h last %b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                exp_res = expected_depths.pop_front();
                exp_data = {2'b00, exp_res.dy, exp_res.dx, exp_res.depth};
                if (m_axis_tdata !== exp_data || m_axis_tlast !== exp_res.last)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MISMATCH_SHOWN)
                        $display("mismatch: depth %0d/%0d dx %0d/%0d dy %0d/%0d last %b/%b",
                                 exp_res.depth, m_axis_tdata[11:0],
                                 $signed(exp_res.dx), $signed(m_axis_tdata[16:12]),
                                 $signed(exp_res.dy), $signed(m_axis_tdata[21:17]),
                                 exp_res.last, m_axis_tlast);
                end
            end
        end
        m_axis_tready <= !(hold_left > 0) &&
                         !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 78) ||
                           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 23));
    end

    // Stimulus sequence
    initial
    begin
        int total;
        cfg_w = IMAGE_WIDTH_RST;
        cfg_h = IMAGE_HEIGHT_RST;
        cfg_bw = BOX_HALF_RST;
        cfg_bh = BOX_HALF_RST;
        cfg_sr = SEARCH_RST;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_complete = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: a drain with nothing ready, then a checkerboard matched one pixel over
        set_config(12'd5, 12'd4, 12'd1, 12'd1, 12'd1);
        queue_req(CMD_DRAIN, 8'd0, 8'd0);
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 5; x++)
                queue_req(CMD_PIXEL, ((x + y) % 2) ? 8'd255 : 8'd0,
                          ((x + y) % 2) ? 8'd0 : 8'd255);
        while (frame_complete)
            queue_req(CMD_DRAIN, 8'd0, 8'd0);

        // Directed: single-pixel frame with zero search range
        set_config(12'd1, 12'd1, 12'd0, 12'd0, 12'd0);
        queue_req(CMD_PIXEL, 8'd255, 8'd0);

        // Largest box and search on a small frame; most pixels are border
        idle_mode <= IDLE_BOTH;
        set_config(12'd17, 12'd17, 12'd8, 12'd8, 12'd8);
        queue_frame(10);

        // Widest row, one line high
        idle_mode <= IDLE_SEND;
        set_config(12'd1024, 12'd1, 12'd0, 12'd0, 12'd1);
        queue_frame(5);

        // Out-of-range writes that clamp; all pixels fall on the border
        idle_mode <= IDLE_RECV;
        set_config(12'hFFF, 12'd0, 12'd15, 12'd15, 12'd15);
        queue_frame(5);

        // Tallest frame, one column, with a long receiver hold-off
        idle_mode <= IDLE_NONE;
        set_config(12'd1, 12'd4095, 12'd0, 12'd0, 12'd0);
        hold_request <= 1'b1;
        queue_frame(3);

        // Random settings on small frames, rotating through the idling modes
        total = 0;
        while (total < 900)
        begin
            case (phases_run % 4)
                0: idle_mode <= IDLE_NONE;
                1: idle_mode <= IDLE_SEND;
                2: idle_mode <= IDLE_RECV;
                default: idle_mode <= IDLE_BOTH;
            endcase
            set_config(CFG_DATA_W'($urandom_range(1, 12)), CFG_DATA_W'($urandom_range(1, 10)),
                       CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 3)),
                       ($urandom_range(0, 5) == 0) ? 12'd8 : CFG_DATA_W'($urandom_range(0, 4)));
            total = total + pending_reqs.size();
            for (int f = $urandom_range(1, 2); f > 0; f--)
                queue_frame($urandom_range(0, 30));
            total = total + pending_reqs.size();
        end

        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_depths.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Run covered %0d configuration phases, %0d requests and %0d depth results.",
                 phases_run, reqs_sent, results_seen);
        if (mismatches == 0 && expected_depths.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/sbm_pkg.sv
hw/rtl/sbm_ram.sv
hw/rtl/sbm_sqrt.sv
hw/rtl/stereo_block_match_depth.sv
bench/stereo_block_match_depth_tb.sv
